@@ src/llcp_pkg.sv @@
`default_nettype none
package llcp_pkg;

  localparam int CMD_W     = 2;
  localparam int CPU_W     = 6;
  localparam int CLN_W     = 7;
  localparam int MASK_W    = 64;
  localparam int LOAD_W    = 32;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0]  CPU_COUNT_RST = 7'd64;
  localparam logic [LOAD_W-1:0] LOAD_MAX      = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_MAP,
    CMD_RUN,
    CMD_STOP,
    CMD_SELECT
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLUSTER_COUNT,
    CFG_CPU_COUNT
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD_LOAD,
    ST_WR_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic tbl_we;
    logic tbl_rd;
    logic load_we;
    logic scan_issue;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t op;
    logic cpu_ok;
    logic sel_en;
    logic scan_done;
    logic cid_ok;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ src/least_loaded_cluster_picker_unit.sv @@
// before output load: map decodes; run/stop also reads and writes the cluster load (no write if
// not in use); select walks min(cpu_count, NUM_CPUS) table entries and drains if any clusters
// throughput: one word in flight, the next is accepted in the cycle after the result loads;
// the select walk of one cpu table read per cycle sets it, a stalled result word delays the load
// reset: control state, cluster count cleared, cpu count set to 64; cpu table and loads read zero
// through per-entry valid bits, no clearing pass
`default_nettype none
module least_loaded_cluster_picker_unit import llcp_pkg::*; #(
  parameter int NUM_CPUS     = 64,
  parameter int NUM_CLUSTERS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [CMD_W-1:0]     cmd,
  input  wire logic [CPU_W-1:0]     cpu_index,
  input  wire logic [CLN_W-1:0]     cluster_number,
  input  wire logic [MASK_W-1:0]    affinity_mask,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      found,
  output logic [CPU_W-1:0]          chosen_cluster,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  assign cfg_ready = 1'b1;

  llcp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dstat     (dstat),
    .dcmd      (dcmd)
  );

  llcp_dp #(
    .NUM_CPUS     (NUM_CPUS),
    .NUM_CLUSTERS (NUM_CLUSTERS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .dcmd           (dcmd),
    .dstat          (dstat),
    .cmd            (cmd),
    .cpu_index      (cpu_index),
    .cluster_number (cluster_number),
    .affinity_mask  (affinity_mask),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .found          (found),
    .chosen_cluster (chosen_cluster)
  );

endmodule
`default_nettype wire

@@ src/llcp_ctrl.sv @@
`default_nettype none
module llcp_ctrl import llcp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire dp_stat_t dstat,
  output dp_cmd_t       dcmd
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    dcmd       = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          dcmd.capture = 1'b1;
          state_next   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (dstat.op)
          CMD_MAP: begin
            dcmd.tbl_we = dstat.cpu_ok;
            state_next  = ST_FIN;
          end
          CMD_RUN, CMD_STOP: begin
            if (dstat.cpu_ok) begin
              dcmd.tbl_rd = 1'b1;
              state_next  = ST_RD_LOAD;
            end else begin
              state_next = ST_FIN;
            end
          end
          CMD_SELECT: begin
            state_next = dstat.sel_en ? ST_SCAN : ST_FIN;
          end
          default: state_next = ST_FIN;
        endcase
      end
      ST_RD_LOAD: begin
        state_next = dstat.cid_ok ? ST_WR_LOAD : ST_FIN;
      end
      ST_WR_LOAD: begin
        dcmd.load_we = 1'b1;
        state_next   = ST_FIN;
      end
      ST_SCAN: begin
        if (dstat.scan_done) begin
          state_next = ST_DRAIN;
        end else begin
          dcmd.scan_issue = 1'b1;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || !out_stall) begin
          dcmd.out_load = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (dcmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule
`default_nettype wire

@@ src/llcp_dp.sv @@
`default_nettype none
module llcp_dp import llcp_pkg::*; #(
  parameter int NUM_CPUS     = 64,
  parameter int NUM_CLUSTERS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dp_cmd_t              dcmd,
  output dp_stat_t                  dstat,
  input  wire logic [CMD_W-1:0]     cmd,
  input  wire logic [CPU_W-1:0]     cpu_index,
  input  wire logic [CLN_W-1:0]     cluster_number,
  input  wire logic [MASK_W-1:0]    affinity_mask,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output logic                      found,
  output logic [CPU_W-1:0]          chosen_cluster
);

  localparam int CPU_AW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int CL_AW  = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
  localparam logic [CFG_W-1:0] NCPU = CFG_W'(NUM_CPUS);
  localparam logic [CLN_W-1:0] NCL  = CLN_W'(NUM_CLUSTERS);

  cmd_t              op;
  logic [CPU_W-1:0]  cpu;
  logic [CLN_W-1:0]  num;
  logic [MASK_W-1:0] mask;
  logic [CFG_W-1:0]  cluster_count;
  logic [CFG_W-1:0]  cpu_count;
  logic [CFG_W-1:0]  scan_idx;
  logic [CFG_W-1:0]  limit;

  logic [CLN_W-1:0]  tbl_mem [NUM_CPUS];
  logic [NUM_CPUS-1:0] tbl_vld;
  logic [CLN_W-1:0]  tbl_data;
  logic              tbl_data_vld;
  logic [CPU_AW-1:0] tbl_ra;
  logic [CLN_W-1:0]  cid;
  logic              cid_ok;

  logic [LOAD_W-1:0] load_mem [NUM_CLUSTERS];
  logic [NUM_CLUSTERS-1:0] load_vld;
  logic [LOAD_W-1:0] load_data;
  logic              load_data_vld;
  logic [CL_AW-1:0]  load_a;
  logic [LOAD_W-1:0] load_eff;
  logic [LOAD_W-1:0] load_new;

  logic              s1_v;
  logic              s2_v;
  logic [CPU_W-1:0]  s2_cid;
  logic [LOAD_W-1:0] lowest_load;
  logic [CPU_W-1:0]  best;
  logic              found_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count <= '0;
      cpu_count     <= CPU_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CLUSTER_COUNT: cluster_count <= cfg_data;
        CFG_CPU_COUNT:     cpu_count     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.capture) begin
      op   <= cmd_t'(cmd);
      cpu  <= cpu_index;
      num  <= cluster_number;
      mask <= affinity_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (dcmd.capture) begin
      scan_idx <= '0;
    end else if (dcmd.scan_issue) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  assign limit  = (cpu_count < NCPU) ? cpu_count : NCPU;
  assign tbl_ra = dcmd.scan_issue ? scan_idx[CPU_AW-1:0] : cpu[CPU_AW-1:0];

  // cpu to cluster table
  always_ff @(posedge clk) begin
    if (dcmd.tbl_we) begin
      tbl_mem[cpu[CPU_AW-1:0]] <= num;
    end
    if (dcmd.tbl_rd || dcmd.scan_issue) begin
      tbl_data     <= tbl_mem[tbl_ra];
      tbl_data_vld <= tbl_vld[tbl_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_vld <= '0;
    end else if (dcmd.tbl_we) begin
      tbl_vld[cpu[CPU_AW-1:0]] <= 1'b1;
    end
  end

  assign cid    = tbl_data_vld ? tbl_data : '0;
  assign cid_ok = (cid < cluster_count) && (cid < NCL);
  assign load_a = cid[CL_AW-1:0];

  // per-cluster load
  always_ff @(posedge clk) begin
    if (dcmd.load_we) begin
      load_mem[load_a] <= load_new;
    end
    load_data     <= load_mem[load_a];
    load_data_vld <= load_vld[load_a];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_vld <= '0;
    end else if (dcmd.load_we) begin
      load_vld[load_a] <= 1'b1;
    end
  end

  assign load_eff = load_data_vld ? load_data : '0;
  assign load_new = (op == CMD_RUN) ? (load_eff + 1'b1) : (load_eff - 1'b1);

  // scan pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= dcmd.scan_issue && mask[scan_idx[CPU_W-1:0]];
      s2_v <= s1_v && cid_ok;
    end
  end

  always_ff @(posedge clk) begin
    s2_cid <= cid[CPU_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found_q <= 1'b0;
    end else if (dcmd.capture) begin
      found_q <= 1'b0;
    end else if (s2_v && (load_eff < lowest_load)) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.capture) begin
      lowest_load <= LOAD_MAX;
      best        <= '0;
    end else if (s2_v && (load_eff < lowest_load)) begin
      lowest_load <= load_eff;
      best        <= s2_cid;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.out_load) begin
      found          <= found_q;
      chosen_cluster <= best;
    end
  end

  always_comb begin
    dstat.op        = op;
    dstat.cpu_ok    = {1'b0, cpu} < NCPU;
    dstat.sel_en    = cluster_count != '0;
    dstat.scan_done = scan_idx >= limit;
    dstat.cid_ok    = cid_ok;
  end

endmodule
`default_nettype wire
